### rtl/core/ppmsp_pkg.sv
// ----------------------------------------------------------------------------
// ppmsp_pkg
// Shared types and constants for the PPM stream parser: parse phases, result
// kinds and the entry format carried from the parser to the output stage.
// ----------------------------------------------------------------------------
package ppmsp_pkg;

  typedef enum logic [3:0] {
    PH_WAIT_P,
    PH_MAGIC,
    PH_MAGIC_TAIL,
    PH_WS_FIRST,
    PH_COMMENT,
    PH_AFTER_CMT,
    PH_WS_W,
    PH_WIDTH,
    PH_WIDTH_TAIL,
    PH_WS_H,
    PH_HEIGHT,
    PH_HEIGHT_TAIL,
    PH_WS_M,
    PH_MAXV,
    PH_MAXV_TAIL,
    PH_PIXELS
  } phase_t;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // parser-to-output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [7:0]  magic;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] maxval;
    logic [15:0] offset;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } q_entry_t;

endpackage

### rtl/core/ppmsp_front.sv
// ----------------------------------------------------------------------------
// ppmsp_front
// Header parser. Takes one file byte per beat, tracks the parse phase and
// pushes a header entry or a raw pixel entry into the queue.
// ----------------------------------------------------------------------------
module ppmsp_front #(
  parameter int DIM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tuser,
  input  logic                q_full,
  output logic                push,
  output ppmsp_pkg::q_entry_t push_data
);

  localparam int DW = (DIM_BITS < 16) ? DIM_BITS : 16;
  localparam int PW = 2 * DW;
  localparam logic [15:0] DimLimit = 16'((64'd1 << DW) - 64'd1);

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ppmsp_pkg::CH_SPACE) || (b == ppmsp_pkg::CH_TAB) ||
           (b == ppmsp_pkg::CH_CR) || (b == ppmsp_pkg::CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ppmsp_pkg::CH_ZERO) && (b <= ppmsp_pkg::CH_NINE);
  endfunction

  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] b);
    logic [20:0] v;
    v = {2'b0, acc, 3'b0} + {4'b0, acc, 1'b0} + {13'b0, b - ppmsp_pkg::CH_ZERO};
    return (v > 21'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  ppmsp_pkg::phase_t phase, phase_next, cur_phase;
  logic [15:0]   accum, accum_next;
  logic [7:0]    magic, magic_next;
  logic [DW-1:0] width, width_next;
  logic [DW-1:0] height, height_next;
  logic [15:0]   maxval, maxval_next;
  logic [15:0]   pos, pos_next, cur_pos;
  logic [1:0]    chan, chan_next;
  logic [7:0]    held_red, held_red_next;
  logic [7:0]    held_green, held_green_next;
  logic [PW-1:0] pixels_left, pixels_left_next;
  logic [PW-1:0] pix_prod;
  logic [7:0]    b;
  logic          ws, dig, accept;

  // no beat is taken while reset is held
  assign s_tready  = !q_full && !rst;
  assign accept    = s_tvalid && s_tready;
  assign b         = s_tdata;
  assign ws        = is_ws(b);
  assign dig       = is_digit(b);
  // frame start restarts the parse before this byte is looked at
  assign cur_phase = s_tuser ? ppmsp_pkg::PH_WAIT_P : phase;
  assign cur_pos   = s_tuser ? 16'd0 : pos;
  assign pos_next  = (cur_pos == 16'hFFFF) ? cur_pos : cur_pos + 16'd1;
  assign pix_prod  = width * height;

  always_comb begin
    phase_next = cur_phase;
    case (cur_phase)
      ppmsp_pkg::PH_WAIT_P: begin
        if (b == ppmsp_pkg::CH_P) phase_next = ppmsp_pkg::PH_MAGIC;
      end
      ppmsp_pkg::PH_MAGIC, ppmsp_pkg::PH_MAGIC_TAIL: begin
        if (ws) phase_next = ppmsp_pkg::PH_WS_FIRST;
        else if (!(cur_phase == ppmsp_pkg::PH_MAGIC && dig))
          phase_next = ppmsp_pkg::PH_MAGIC_TAIL;
      end
      ppmsp_pkg::PH_WS_FIRST, ppmsp_pkg::PH_AFTER_CMT: begin
        if (b == ppmsp_pkg::CH_HASH) phase_next = ppmsp_pkg::PH_COMMENT;
        else if (ws)
          phase_next = (cur_phase == ppmsp_pkg::PH_AFTER_CMT) ? ppmsp_pkg::PH_WS_W
                                                              : ppmsp_pkg::PH_WS_FIRST;
        else phase_next = dig ? ppmsp_pkg::PH_WIDTH : ppmsp_pkg::PH_WIDTH_TAIL;
      end
      ppmsp_pkg::PH_COMMENT: begin
        if (b == ppmsp_pkg::CH_LF) phase_next = ppmsp_pkg::PH_AFTER_CMT;
      end
      ppmsp_pkg::PH_WS_W: begin
        if (!ws) phase_next = dig ? ppmsp_pkg::PH_WIDTH : ppmsp_pkg::PH_WIDTH_TAIL;
      end
      ppmsp_pkg::PH_WIDTH, ppmsp_pkg::PH_WIDTH_TAIL: begin
        if (ws) phase_next = ppmsp_pkg::PH_WS_H;
        else if (!(cur_phase == ppmsp_pkg::PH_WIDTH && dig))
          phase_next = ppmsp_pkg::PH_WIDTH_TAIL;
      end
      ppmsp_pkg::PH_WS_H: begin
        if (!ws) phase_next = dig ? ppmsp_pkg::PH_HEIGHT : ppmsp_pkg::PH_HEIGHT_TAIL;
      end
      ppmsp_pkg::PH_HEIGHT, ppmsp_pkg::PH_HEIGHT_TAIL: begin
        if (ws) phase_next = ppmsp_pkg::PH_WS_M;
        else if (!(cur_phase == ppmsp_pkg::PH_HEIGHT && dig))
          phase_next = ppmsp_pkg::PH_HEIGHT_TAIL;
      end
      ppmsp_pkg::PH_WS_M: begin
        if (!ws) phase_next = dig ? ppmsp_pkg::PH_MAXV : ppmsp_pkg::PH_MAXV_TAIL;
      end
      ppmsp_pkg::PH_MAXV, ppmsp_pkg::PH_MAXV_TAIL: begin
        if (ws) phase_next = ppmsp_pkg::PH_PIXELS;
        else if (!(cur_phase == ppmsp_pkg::PH_MAXV && dig))
          phase_next = ppmsp_pkg::PH_MAXV_TAIL;
      end
      default: phase_next = cur_phase;
    endcase
  end

  always_comb begin
    accum_next       = accum;
    magic_next       = magic;
    width_next       = width;
    height_next      = height;
    maxval_next      = maxval;
    chan_next        = chan;
    held_red_next    = held_red;
    held_green_next  = held_green;
    pixels_left_next = pixels_left;
    push             = 1'b0;
    push_data        = '0;
    case (cur_phase)
      ppmsp_pkg::PH_WAIT_P: begin
        if (b == ppmsp_pkg::CH_P) accum_next = '0;
      end
      ppmsp_pkg::PH_WS_FIRST, ppmsp_pkg::PH_AFTER_CMT, ppmsp_pkg::PH_WS_W,
      ppmsp_pkg::PH_WS_H, ppmsp_pkg::PH_WS_M: begin
        // first byte of a number; a comment opener or whitespace leaves it alone
        if (!ws && !(b == ppmsp_pkg::CH_HASH && (cur_phase == ppmsp_pkg::PH_WS_FIRST ||
                                                 cur_phase == ppmsp_pkg::PH_AFTER_CMT)))
          accum_next = dig ? {8'd0, b - ppmsp_pkg::CH_ZERO} : 16'd0;
      end
      ppmsp_pkg::PH_MAGIC, ppmsp_pkg::PH_MAGIC_TAIL: begin
        if (ws) magic_next = (accum > 16'd255) ? 8'hFF : accum[7:0];
        else if (cur_phase == ppmsp_pkg::PH_MAGIC && dig) accum_next = add_digit(accum, b);
      end
      ppmsp_pkg::PH_WIDTH, ppmsp_pkg::PH_WIDTH_TAIL: begin
        if (ws) width_next = (accum > DimLimit) ? DimLimit[DW-1:0] : accum[DW-1:0];
        else if (cur_phase == ppmsp_pkg::PH_WIDTH && dig) accum_next = add_digit(accum, b);
      end
      ppmsp_pkg::PH_HEIGHT, ppmsp_pkg::PH_HEIGHT_TAIL: begin
        if (ws) height_next = (accum > DimLimit) ? DimLimit[DW-1:0] : accum[DW-1:0];
        else if (cur_phase == ppmsp_pkg::PH_HEIGHT && dig) accum_next = add_digit(accum, b);
      end
      ppmsp_pkg::PH_MAXV, ppmsp_pkg::PH_MAXV_TAIL: begin
        if (ws) begin
          maxval_next      = accum;
          pixels_left_next = pix_prod;
          chan_next        = 2'd0;
          push             = 1'b1;
          push_data.kind   = ppmsp_pkg::KIND_HEADER;
          push_data.magic  = magic;
          push_data.width  = 16'(width);
          push_data.height = 16'(height);
          push_data.maxval = accum;
          push_data.offset = pos_next;
        end else if (cur_phase == ppmsp_pkg::PH_MAXV && dig) begin
          accum_next = add_digit(accum, b);
        end
      end
      ppmsp_pkg::PH_PIXELS: begin
        if (pixels_left != '0) begin
          case (chan)
            2'd0: begin
              held_red_next = b;
              chan_next     = 2'd1;
            end
            2'd1: begin
              held_green_next = b;
              chan_next       = 2'd2;
            end
            default: begin
              chan_next        = 2'd0;
              pixels_left_next = pixels_left - PW'(1);
              push             = 1'b1;
              push_data.kind   = ppmsp_pkg::KIND_PIXEL;
              push_data.red    = held_red;
              push_data.green  = held_green;
              push_data.blue   = b;
              push_data.last   = (pixels_left == PW'(1));
            end
          endcase
        end
      end
      default: ;
    endcase
    if (!accept) push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ppmsp_pkg::PH_WAIT_P;
      accum       <= '0;
      magic       <= '0;
      width       <= '0;
      height      <= '0;
      maxval      <= '0;
      pos         <= '0;
      chan        <= '0;
      held_red    <= '0;
      held_green  <= '0;
      pixels_left <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      accum       <= accum_next;
      magic       <= magic_next;
      width       <= width_next;
      height      <= height_next;
      maxval      <= maxval_next;
      pos         <= pos_next;
      chan        <= chan_next;
      held_red    <= held_red_next;
      held_green  <= held_green_next;
      pixels_left <= pixels_left_next;
    end
  end

  // a header entry always moves the parser into pixel data
  a_hdr_to_pixels: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.kind == ppmsp_pkg::KIND_HEADER) |=> (phase == ppmsp_pkg::PH_PIXELS))
    else $error("header pushed without entering pixel phase");

  // the last pixel drains the pixel count
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.last) |=> (pixels_left == '0))
    else $error("last pixel left pixels outstanding");

endmodule

### rtl/core/ppmsp_queue.sv
// ----------------------------------------------------------------------------
// ppmsp_queue
// Short first-word-fall-through queue between parser and output stage.
// ----------------------------------------------------------------------------
module ppmsp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ppmsp_pkg::q_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output ppmsp_pkg::q_entry_t pop_data,
  output logic                empty
);

  ppmsp_pkg::q_entry_t slots [ppmsp_pkg::QDEPTH];
  logic [ppmsp_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [ppmsp_pkg::QCNT_W-1:0] count;

  assign full     = (count == ppmsp_pkg::QCNT_W'(ppmsp_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + ppmsp_pkg::QCNT_W'(push) - ppmsp_pkg::QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == ppmsp_pkg::QCNT_W'(ppmsp_pkg::QDEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

### rtl/core/ppmsp_back.sv
// ----------------------------------------------------------------------------
// ppmsp_back
// Output stage. Pops queue entries into the output register, applying the
// channel inversion, if enabled, against the current header's maximum color.
// ----------------------------------------------------------------------------
module ppmsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                invert_enable,
  input  logic                q_empty,
  input  ppmsp_pkg::q_entry_t q_data,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output ppmsp_pkg::q_entry_t out_data
);

  function automatic logic [7:0] chan_out(input logic [7:0] s, input logic [15:0] m,
                                          input logic en);
    logic [15:0] r;
    r = m - {8'd0, s};
    if (!en) return s;
    if ({8'd0, s} >= m) return 8'd0;
    return (r > 16'd255) ? 8'hFF : r[7:0];
  endfunction

  logic [15:0]         maxval;
  ppmsp_pkg::q_entry_t out_next;

  assign pop = !q_empty && (!m_tvalid || m_tready);

  always_comb begin
    out_next = q_data;
    if (q_data.kind == ppmsp_pkg::KIND_PIXEL) begin
      out_next.red   = chan_out(q_data.red, maxval, invert_enable);
      out_next.green = chan_out(q_data.green, maxval, invert_enable);
      out_next.blue  = chan_out(q_data.blue, maxval, invert_enable);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      maxval   <= '0;
    end else begin
      if (pop) begin
        m_tvalid <= 1'b1;
        if (q_data.kind == ppmsp_pkg::KIND_HEADER) maxval <= q_data.maxval;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= out_next;
  end

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_data.last) |-> (out_data.kind == ppmsp_pkg::KIND_PIXEL))
    else $error("last flag on a header beat");

endmodule

### rtl/core/ppm_stream_parser_invert.sv
// ----------------------------------------------------------------------------
// ppm_stream_parser_invert
// Binary PPM stream parser: emits one header beat, then one beat per pixel.
// ----------------------------------------------------------------------------
// Input stream: one file byte per beat on s_tdata; s_tuser marks the first
// byte of a new file and restarts the parse before that byte is used.
// Output stream: m_tuser is 0 for the header beat, 1 for a pixel beat;
// m_tlast flags the final pixel of width * height. Header fields are zero on
// pixel beats and channel fields are zero on the header beat.
// cfg_we/cfg_wdata write invert_enable; when set each channel leaves as
// max color minus sample, clamped to 0..255. Write it only while idle.
// Throughput: one byte per cycle. The parser takes a byte every cycle that the
// four-entry queue to the output stage has room.
// Path: the byte that completes a result is written into the queue, then the
// result is popped into the output register, where m_tvalid marks it valid.
// When m_tready is low the output register holds its beat and the queue
// absorbs up to four more results; bytes that make no result keep flowing
// until the queue fills, then s_tready drops.
// Reset: parse restarts waiting for 'P', byte offset counts from zero,
// queue and output empty, invert_enable cleared.
// ----------------------------------------------------------------------------
module ppm_stream_parser_invert #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] magic_number, [23:8] image_width, [39:24] image_height,
  // [55:40] max_color_value, [71:56] data_offset, [79:72] red,
  // [87:80] green, [95:88] blue
  output logic [95:0] m_tdata,
  output logic        m_tuser,   // [0] result_kind
  output logic        m_tlast,   // last_pixel
  input  logic        cfg_we,
  input  logic        cfg_wdata  // invert_enable
);

  logic                invert_enable;
  logic                push, pop, q_full, q_empty;
  ppmsp_pkg::q_entry_t push_data, q_data, out_data;

  always_ff @(posedge clk) begin
    if (rst) invert_enable <= 1'b0;
    else if (cfg_we) invert_enable <= cfg_wdata;
  end

  ppmsp_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ppmsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  ppmsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .invert_enable (invert_enable),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_data      (out_data)
  );

  assign m_tdata = {out_data.blue, out_data.green, out_data.red, out_data.offset,
                    out_data.maxval, out_data.height, out_data.width, out_data.magic};
  assign m_tuser = out_data.kind;
  assign m_tlast = out_data.last;

endmodule
